// File: sv/tmts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tmts_pkg;

  localparam int POS_W   = 32;
  localparam int TIME_W  = 48;
  localparam int SPEED_W = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_TOP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_FLOOR = 2'd2;

  localparam logic [CFG_W-1:0] ACCEL_RST       = 16'd1000;
  localparam logic [CFG_W-1:0] SPEED_TOP_RST   = 16'd4000;
  localparam logic [CFG_W-1:0] SPEED_FLOOR_RST = 16'd1;

  localparam logic [TIME_W-1:0]  TIME_MAX   = {TIME_W{1'b1}};
  localparam logic [SPEED_W-1:0] SPEED_CLIP = {SPEED_W{1'b1}};

  typedef struct packed {
    logic signed [POS_W-1:0] start_pos;
    logic signed [POS_W-1:0] end_pos;
    logic [TIME_W-1:0]       want_duration;
  } tmts_req_t;

  typedef struct packed {
    logic [TIME_W-1:0]  min_time;
    logic [TIME_W-1:0]  max_time;
    logic [TIME_W-1:0]  used_duration;
    logic [SPEED_W-1:0] cruise_speed;
    logic               time_saturated;
  } tmts_res_t;

endpackage

`default_nettype wire

// File: sv/tmts_div.sv
`timescale 1ns / 1ps
`default_nettype none

module tmts_div #(
  parameter int NW = 48,
  parameter int DW = 16,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [NW-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  logic          vld [1:NW];
  logic [NW-1:0] nq  [1:NW];
  logic [DW-1:0] rem [1:NW];
  logic [DW-1:0] dv  [1:NW];
  logic [SW-1:0] sd  [1:NW];

  // restoring division, one quotient bit per stage; quotient shifts into nq
  for (genvar i = 0; i < NW; i++) begin : g_step
    logic          cur_v;
    logic [NW-1:0] cur_nq;
    logic [DW-1:0] cur_rem;
    logic [DW-1:0] cur_dv;
    logic [SW-1:0] cur_sd;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          take;

    if (i == 0) begin : g_head
      assign cur_v   = in_valid;
      assign cur_nq  = in_num;
      assign cur_rem = '0;
      assign cur_dv  = in_den;
      assign cur_sd  = in_side;
    end else begin : g_body
      assign cur_v   = vld[i];
      assign cur_nq  = nq[i];
      assign cur_rem = rem[i];
      assign cur_dv  = dv[i];
      assign cur_sd  = sd[i];
    end

    assign trial = {cur_rem, cur_nq[NW-1]};
    assign take  = trial >= {1'b0, cur_dv};
    assign diff  = trial - {1'b0, cur_dv};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= cur_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nq[i+1]  <= {cur_nq[NW-2:0], take};
        rem[i+1] <= take ? diff[DW-1:0] : trial[DW-1:0];
        dv[i+1]  <= cur_dv;
        sd[i+1]  <= cur_sd;
      end
    end
  end

  assign out_valid = vld[NW];
  assign out_quo   = nq[NW];
  assign out_side  = sd[NW];

endmodule

`default_nettype wire

// File: sv/tmts_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none

module tmts_sqrt #(
  parameter int W  = 66,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [W-1:0]    in_rad,
  input  logic [SW-1:0]   in_side,
  output logic            out_valid,
  output logic [W/2-1:0]  out_root,
  output logic            out_inexact,
  output logic [SW-1:0]   out_side
);

  localparam int R = W / 2;

  logic          vld  [1:R];
  logic [W-1:0]  rad  [1:R];
  logic [R-1:0]  root [1:R];
  logic [R:0]    rem  [1:R];
  logic [SW-1:0] sd   [1:R];

  // digit recurrence, one root bit (two radicand bits) per stage
  for (genvar i = 0; i < R; i++) begin : g_step
    logic          cur_v;
    logic [W-1:0]  cur_rad;
    logic [R-1:0]  cur_root;
    logic [R:0]    cur_rem;
    logic [SW-1:0] cur_sd;
    logic [R+2:0]  t;
    logic [R+2:0]  trial;
    logic [R+2:0]  diff;
    logic          take;

    if (i == 0) begin : g_head
      assign cur_v    = in_valid;
      assign cur_rad  = in_rad;
      assign cur_root = '0;
      assign cur_rem  = '0;
      assign cur_sd   = in_side;
    end else begin : g_body
      assign cur_v    = vld[i];
      assign cur_rad  = rad[i];
      assign cur_root = root[i];
      assign cur_rem  = rem[i];
      assign cur_sd   = sd[i];
    end

    assign t     = {cur_rem, cur_rad[W-1:W-2]};
    assign trial = {1'b0, cur_root, 2'b01};
    assign take  = t >= trial;
    assign diff  = t - trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= cur_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad[i+1]  <= {cur_rad[W-3:0], 2'b00};
        root[i+1] <= {cur_root[R-2:0], take};
        rem[i+1]  <= take ? diff[R:0] : t[R:0];
        sd[i+1]   <= cur_sd;
      end
    end
  end

  assign out_valid   = vld[R];
  assign out_root    = root[R];
  assign out_inexact = rem[R] != '0;
  assign out_side    = sd[R];

endmodule

`default_nettype wire

// File: sv/trapezoid_move_time_speed_solver_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Trapezoid move-time and cruise-speed solver.
// Request channel (req_valid / req_stall / req_data) carries start and end
// position and the wanted duration; the result channel (res_valid / res_stall /
// res_data) returns min, max and clamped duration, cruise speed and a flag set
// when the minimum time saturated.
// Fully pipelined: one request per cycle while req_stall is low. Depth is set by
// the bit-per-stage dividers (48 and 66 stages) and square roots (33 and 64
// stages). The accel, speed_top and speed_floor registers are written through
// cfg_write, cfg_index and cfg_data; the user must write them only while no
// request is in flight (not enforced by the block); a zero is taken as one.
// Reset (rst, synchronous) empties the pipeline and loads the register defaults.
// When the receiver stalls, the result holds in the output register and one more
// result parks in a skid register; req_stall then rises and the whole pipeline
// freezes until the skid register drains. Nothing is lost or repeated.
module trapezoid_move_time_speed_solver_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  tmts_pkg::tmts_req_t           req_data,
  output logic                          res_valid,
  input  logic                          res_stall,
  output tmts_pkg::tmts_res_t           res_data,
  input  logic                          cfg_write,
  input  logic [tmts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tmts_pkg::CFG_W-1:0]    cfg_data
);

  import tmts_pkg::*;

  typedef struct packed {
    logic [47:0] want;
    logic [47:0] xa;
    logic [31:0] x;
    logic [48:0] num;
    logic [31:0] den;
    logic        trap;
    logic        sat;
  } seg1_t;

  typedef struct packed {
    logic [47:0] want;
    logic [47:0] xa;
    logic        trap;
    logic        sat;
    logic [47:0] tmax;
  } seg2_t;

  typedef struct packed {
    logic [47:0] want;
    logic [47:0] xa;
    logic        trap;
    logic        sat;
    logic [47:0] tmax;
    logic [47:0] quo;
  } seg3_t;

  typedef struct packed {
    logic [63:0] p;
    logic        eq;
    logic [47:0] tmin;
    logic [47:0] tmax;
    logic [47:0] used;
    logic        sat;
  } seg4_t;

  // configuration
  logic [CFG_W-1:0] accel;
  logic [CFG_W-1:0] speed_top;
  logic [CFG_W-1:0] speed_floor;
  logic [CFG_W-1:0] a_eff;
  logic [CFG_W-1:0] vt_eff;
  logic [CFG_W-1:0] vf_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel       <= ACCEL_RST;
      speed_top   <= SPEED_TOP_RST;
      speed_floor <= SPEED_FLOOR_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ACCEL:       accel       <= cfg_data;
        CFG_SPEED_TOP:   speed_top   <= cfg_data;
        CFG_SPEED_FLOOR: speed_floor <= cfg_data;
        default: ;
      endcase
    end
  end

  assign a_eff  = (accel == '0) ? 16'd1 : accel;
  assign vt_eff = (speed_top == '0) ? 16'd1 : speed_top;
  assign vf_eff = (speed_floor == '0) ? 16'd1 : speed_floor;

  logic en;
  logic skid_valid;

  assign en        = ~skid_valid;
  assign req_stall = skid_valid;

  // stage 0: capture request
  logic      s0_v;
  tmts_req_t s0_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else if (en) begin
      s0_v <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_req <= req_data;
    end
  end

  // stage 1: distance
  logic        s1_v;
  logic [31:0] s1_x;
  logic [47:0] s1_want;
  logic [32:0] s1_diff;
  logic [32:0] s1_abs;

  assign s1_diff = {s0_req.end_pos[31], s0_req.end_pos}
                 - {s0_req.start_pos[31], s0_req.start_pos};
  assign s1_abs  = s1_diff[32] ? (33'd0 - s1_diff) : s1_diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= s0_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x    <= s1_abs[31:0];
      s1_want <= s0_req.want_duration;
    end
  end

  // stage 2: products
  logic        s2_v;
  logic [31:0] s2_x;
  logic [47:0] s2_want;
  logic [47:0] s2_xa;
  logic [31:0] s2_vt2;
  logic [31:0] s2_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_x    <= s1_x;
      s2_want <= s1_want;
      s2_xa   <= {16'd0, s1_x} * {32'd0, a_eff};
      s2_vt2  <= {16'd0, vt_eff} * {16'd0, vt_eff};
      s2_den  <= {16'd0, a_eff} * {16'd0, vt_eff};
    end
  end

  // stage 3: profile choice and saturation check
  logic        s3_v;
  seg1_t       s3_seg;
  logic [48:0] s3_num;
  logic        s3_trap;

  assign s3_trap = s2_xa > {16'd0, s2_vt2};
  assign s3_num  = {1'b0, s2_xa} + {17'd0, s2_vt2};

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_seg.want <= s2_want;
      s3_seg.xa   <= s2_xa;
      s3_seg.x    <= s2_x;
      s3_seg.num  <= s3_num;
      s3_seg.den  <= s2_den;
      s3_seg.trap <= s3_trap;
      s3_seg.sat  <= s3_trap && ({15'd0, s3_num} >= {s2_den, 32'd0});
    end
  end

  // longest time: x * 2^16 / speed_floor
  logic        d1_v;
  logic [47:0] d1_quo;
  seg1_t       d1_side;

  tmts_div #(.NW(48), .DW(16), .SW($bits(seg1_t))) u_div_tmax (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s3_v),
    .in_num   ({s3_seg.x, 16'd0}),
    .in_den   (vf_eff),
    .in_side  (s3_seg),
    .out_valid(d1_v),
    .out_quo  (d1_quo),
    .out_side (d1_side)
  );

  // shortest time: trapezoid quotient or triangle radicand
  logic [65:0] d2_num_in;
  logic [31:0] d2_den_in;
  seg2_t       d2_in;
  logic        d2_v;
  logic [65:0] d2_quo;
  seg2_t       d2_side;

  assign d2_num_in = d1_side.trap ? {1'b0, d1_side.num, 16'd0} : {d1_side.x, 34'd0};
  assign d2_den_in = d1_side.trap ? d1_side.den : {16'd0, a_eff};

  always_comb begin
    d2_in.want = d1_side.want;
    d2_in.xa   = d1_side.xa;
    d2_in.trap = d1_side.trap;
    d2_in.sat  = d1_side.sat;
    d2_in.tmax = d1_quo;
  end

  tmts_div #(.NW(66), .DW(32), .SW($bits(seg2_t))) u_div_tmin (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (d1_v),
    .in_num   (d2_num_in),
    .in_den   (d2_den_in),
    .in_side  (d2_in),
    .out_valid(d2_v),
    .out_quo  (d2_quo),
    .out_side (d2_side)
  );

  seg3_t       q1_in;
  logic        q1_v;
  logic [32:0] q1_root;
  logic        q1_inexact;
  seg3_t       q1_side;

  always_comb begin
    q1_in.want = d2_side.want;
    q1_in.xa   = d2_side.xa;
    q1_in.trap = d2_side.trap;
    q1_in.sat  = d2_side.sat;
    q1_in.tmax = d2_side.tmax;
    q1_in.quo  = d2_quo[47:0];
  end

  tmts_sqrt #(.W(66), .SW($bits(seg3_t))) u_sqrt_tri (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (d2_v),
    .in_rad     (d2_quo),
    .in_side    (q1_in),
    .out_valid  (q1_v),
    .out_root   (q1_root),
    .out_inexact(q1_inexact),
    .out_side   (q1_side)
  );

  // stage A: pick min time, clamp duration
  logic        sa_v;
  logic [47:0] sa_tmin;
  logic [47:0] sa_tmax;
  logic [47:0] sa_used;
  logic [47:0] sa_xa;
  logic        sa_sat;
  logic [47:0] sa_tmin_next;
  logic [47:0] sa_used_next;

  always_comb begin
    if (q1_side.trap) begin
      sa_tmin_next = q1_side.sat ? TIME_MAX : q1_side.quo;
    end else begin
      sa_tmin_next = {15'd0, q1_root};
    end
    if (q1_side.want >= q1_side.tmax) begin
      sa_used_next = q1_side.tmax;
    end else if (q1_side.want <= sa_tmin_next) begin
      sa_used_next = sa_tmin_next;
    end else begin
      sa_used_next = q1_side.want;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sa_v <= 1'b0;
    end else if (en) begin
      sa_v <= q1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_tmin <= sa_tmin_next;
      sa_tmax <= q1_side.tmax;
      sa_used <= sa_used_next;
      sa_xa   <= q1_side.xa;
      sa_sat  <= q1_side.sat;
    end
  end

  // stage B: p = accel * duration
  logic         sb_v;
  logic [63:0]  sb_p;
  logic [127:0] sb_m;
  logic         sb_eq;
  logic [47:0]  sb_tmin;
  logic [47:0]  sb_tmax;
  logic [47:0]  sb_used;
  logic         sb_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      sb_v <= 1'b0;
    end else if (en) begin
      sb_v <= sa_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_p    <= {48'd0, a_eff} * {16'd0, sa_used};
      sb_m    <= {46'd0, sa_xa, 34'd0};
      sb_eq   <= sa_used == sa_tmin;
      sb_tmin <= sa_tmin;
      sb_tmax <= sa_tmax;
      sb_used <= sa_used;
      sb_sat  <= sa_sat;
    end
  end

  // stage C: partial products of p * p
  logic         sc_v;
  logic [63:0]  sc_hh;
  logic [63:0]  sc_hl;
  logic [63:0]  sc_ll;
  logic [127:0] sc_m;
  seg4_t        sc_seg;

  always_ff @(posedge clk) begin
    if (rst) begin
      sc_v <= 1'b0;
    end else if (en) begin
      sc_v <= sb_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc_hh       <= {32'd0, sb_p[63:32]} * {32'd0, sb_p[63:32]};
      sc_hl       <= {32'd0, sb_p[63:32]} * {32'd0, sb_p[31:0]};
      sc_ll       <= {32'd0, sb_p[31:0]} * {32'd0, sb_p[31:0]};
      sc_m        <= sb_m;
      sc_seg.p    <= sb_p;
      sc_seg.eq   <= sb_eq;
      sc_seg.tmin <= sb_tmin;
      sc_seg.tmax <= sb_tmax;
      sc_seg.used <= sb_used;
      sc_seg.sat  <= sb_sat;
    end
  end

  // stage D: sum to p^2
  logic         sd_v;
  logic [127:0] sd_sq;
  logic [127:0] sd_m;
  seg4_t        sd_seg;

  always_ff @(posedge clk) begin
    if (rst) begin
      sd_v <= 1'b0;
    end else if (en) begin
      sd_v <= sc_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_sq  <= {sc_hh, 64'd0} + {31'd0, sc_hl, 33'd0} + {64'd0, sc_ll};
      sd_m   <= sc_m;
      sd_seg <= sc_seg;
    end
  end

  // stage E: discriminant, clipped at zero
  logic         se_v;
  logic [127:0] se_disc;
  seg4_t        se_seg;

  always_ff @(posedge clk) begin
    if (rst) begin
      se_v <= 1'b0;
    end else if (en) begin
      se_v <= sd_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      se_disc <= (sd_sq >= sd_m) ? (sd_sq - sd_m) : '0;
      se_seg  <= sd_seg;
    end
  end

  logic        q2_v;
  logic [63:0] q2_root;
  logic        q2_inexact;
  seg4_t       q2_side;

  tmts_sqrt #(.W(128), .SW($bits(seg4_t))) u_sqrt_disc (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (se_v),
    .in_rad     (se_disc),
    .in_side    (se_seg),
    .out_valid  (q2_v),
    .out_root   (q2_root),
    .out_inexact(q2_inexact),
    .out_side   (q2_side)
  );

  // stage F: round root up, capped at p
  logic        sf_v;
  logic [63:0] sf_c;
  seg4_t       sf_seg;

  always_ff @(posedge clk) begin
    if (rst) begin
      sf_v <= 1'b0;
    end else if (en) begin
      sf_v <= q2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sf_c   <= q2_root + {63'd0, q2_inexact && (q2_root < q2_side.p)};
      sf_seg <= q2_side;
    end
  end

  // stage G: cruise speed
  logic        sg_v;
  tmts_res_t   sg_res;
  logic [63:0] sg_diff;
  logic [15:0] sg_speed;

  assign sg_diff = sf_seg.p - sf_c;

  always_comb begin
    if (sf_seg.eq) begin
      sg_speed = vt_eff;
    end else if (sg_diff[63:33] != '0) begin
      sg_speed = SPEED_CLIP;
    end else begin
      sg_speed = sg_diff[32:17];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sg_v <= 1'b0;
    end else if (en) begin
      sg_v <= sf_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sg_res.min_time       <= sf_seg.tmin;
      sg_res.max_time       <= sf_seg.tmax;
      sg_res.used_duration  <= sf_seg.used;
      sg_res.cruise_speed   <= sg_speed;
      sg_res.time_saturated <= sf_seg.sat;
    end
  end

  // output register with skid
  tmts_res_t skid_res;
  logic      take_in;

  assign take_in = sg_v & en;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!res_valid || !res_stall) begin
      if (skid_valid) begin
        res_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        res_valid <= take_in;
      end
    end else if (take_in) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!res_valid || !res_stall) begin
      res_data <= skid_valid ? skid_res : sg_res;
    end else if (take_in) begin
      skid_res <= sg_res;
    end
  end

endmodule

`default_nettype wire

// File: tb/sv/trapezoid_move_time_speed_solver_unit_tb.sv
`timescale 1ns / 1ps

module trapezoid_move_time_speed_solver_unit_tb;
  import tmts_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  tmts_req_t req_data = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  tmts_res_t res_data;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ACCEL;
  logic [CFG_W-1:0] cfg_data = '0;

  logic [CFG_W-1:0] accel_m = ACCEL_RST;
  logic [CFG_W-1:0] top_m = SPEED_TOP_RST;
  logic [CFG_W-1:0] floor_m = SPEED_FLOOR_RST;

  tmts_req_t move_q[$];
  tmts_res_t plan_q[$];
  int unsigned taken_cnt = 0;
  int unsigned hold_req_cnt = 0;
  bit steady_send = 1'b0;
  bit steady_recv = 1'b0;
  bit failed = 1'b0;

  trapezoid_move_time_speed_solver_unit dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
    .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic bit [63:0] isqrt(bit [127:0] n);
    bit [63:0] r;
    bit [63:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= n) r = c;
    end
    return r;
  endfunction

  function automatic tmts_res_t plan_move(tmts_req_t r);
    tmts_res_t o;
    bit [63:0] a, vt, vf, x, want, num, den, q, rm, tmin, tmax, used, p, c, spd;
    bit [127:0] sq, m, disc;
    longint d;
    bit sat;
    a = (accel_m == 0) ? 64'd1 : 64'(accel_m);
    vt = (top_m == 0) ? 64'd1 : 64'(top_m);
    vf = (floor_m == 0) ? 64'd1 : 64'(floor_m);
    d = longint'(r.end_pos) - longint'(r.start_pos);
    x = (d < 0) ? 64'(-d) : 64'(d);
    want = 64'(r.want_duration);
    sat = 1'b0;
    if (x * a > vt * vt) begin
      num = vt * vt + x * a;
      den = a * vt;
      q = num / den;
      rm = num % den;
      if (q > 64'hFFFF_FFFF) begin
        tmin = 64'(TIME_MAX);
        sat = 1'b1;
      end else begin
        tmin = (q << 16) | ((rm << 16) / den);
      end
    end else begin
      tmin = isqrt(({64'd0, x} << 34) / {64'd0, a});
      if (tmin > 64'(TIME_MAX)) begin
        tmin = 64'(TIME_MAX);
        sat = 1'b1;
      end
    end
    tmax = (x << 16) / vf;
    if (want >= tmax) used = tmax;
    else if (want <= tmin) used = tmin;
    else used = want;
    if (used == tmin) begin
      spd = vt;
    end else begin
      p = a * used;
      sq = {64'd0, p} * {64'd0, p};
      m = {64'd0, a * x} << 34;
      disc = (sq < m) ? 128'd0 : sq - m;
      c = isqrt(disc);
      if ({64'd0, c} * {64'd0, c} != disc && c < p) c++;
      spd = (p - c) >> 17;
      if (spd > 64'hFFFF) spd = 64'hFFFF;
    end
    o.min_time = tmin[TIME_W-1:0];
    o.max_time = tmax[TIME_W-1:0];
    o.used_duration = used[TIME_W-1:0];
    o.cruise_speed = spd[SPEED_W-1:0];
    o.time_saturated = sat;
    return o;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Sender: hold a request until it is taken, then maybe idle before the next.
  int unsigned seen_cnt = 0;
  int unsigned send_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (req_valid && taken_cnt == seen_cnt) begin
        // stalled: keep payload
      end else begin
        seen_cnt = taken_cnt;
        if (req_valid && !steady_send) send_gap = pick_gap();
        if (send_gap > 0) begin
          send_gap--;
          req_valid <= 1'b0;
        end else if (move_q.size() > 0) begin
          req_valid <= 1'b1;
          req_data <= move_q[0];
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when asked for one.
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  always @(negedge clk) begin
    if (hold_req_cnt != hold_seen) begin
      hold_seen = hold_req_cnt;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_stall <= 1'b1;
    end else if (steady_recv) begin
      res_stall <= 1'b0;
    end else begin
      res_stall <= ($urandom_range(0, 99) < 25) ? 1'b1 : (pick_gap() > 3);
    end
  end

  always @(posedge clk) begin
    if (!rst && req_valid && !req_stall) begin
      plan_q.push_back(plan_move(req_data));
      void'(move_q.pop_front());
      taken_cnt++;
    end
  end

  always @(posedge clk) begin
    tmts_res_t e;
    if (!rst && res_valid && !res_stall) begin
      if (plan_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, res_data);
        failed = 1'b1;
      end else begin
        e = plan_q.pop_front();
        if (e.min_time !== res_data.min_time) begin
          $display("%0t: min_time exp %h got %h", $time, e.min_time, res_data.min_time);
          failed = 1'b1;
        end
        if (e.max_time !== res_data.max_time) begin
          $display("%0t: max_time exp %h got %h", $time, e.max_time, res_data.max_time);
          failed = 1'b1;
        end
        if (e.used_duration !== res_data.used_duration) begin
          $display("%0t: used_duration exp %h got %h", $time, e.used_duration,
                   res_data.used_duration);
          failed = 1'b1;
        end
        if (e.cruise_speed !== res_data.cruise_speed) begin
          $display("%0t: cruise_speed exp %h got %h", $time, e.cruise_speed,
                   res_data.cruise_speed);
          failed = 1'b1;
        end
        if (e.time_saturated !== res_data.time_saturated) begin
          $display("%0t: time_saturated exp %b got %b", $time, e.time_saturated,
                   res_data.time_saturated);
          failed = 1'b1;
        end
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_ACCEL: accel_m = val;
      CFG_SPEED_TOP: top_m = val;
      default: floor_m = val;
    endcase
  endtask

  task automatic set_regs(logic [CFG_W-1:0] a, logic [CFG_W-1:0] vt, logic [CFG_W-1:0] vf);
    write_reg(CFG_ACCEL, a);
    write_reg(CFG_SPEED_TOP, vt);
    write_reg(CFG_SPEED_FLOOR, vf);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic add_move(logic signed [31:0] s, logic signed [31:0] e, logic [47:0] w);
    tmts_req_t r;
    r.start_pos = s;
    r.end_pos = e;
    r.want_duration = w;
    move_q.push_back(r);
  endtask

  task automatic add_random_moves(int n);
    tmts_req_t r;
    tmts_res_t b;
    int k;
    for (int i = 0; i < n; i++) begin
      r.start_pos = $urandom;
      k = $urandom_range(0, 31);
      if ($urandom_range(0, 9) == 0) r.end_pos = $urandom;
      else r.end_pos = r.start_pos + (($urandom & ((32'd1 << k) - 1)) * ($urandom_range(0, 1) ? 1 : -1));
      r.want_duration = '0;
      b = plan_move(r);
      case ($urandom_range(0, 9))
        0: r.want_duration = TIME_W'({$urandom, $urandom} & TIME_MAX);
        1: r.want_duration = b.min_time;
        2: r.want_duration = b.max_time;
        3: r.want_duration = '0;
        4: r.want_duration = TIME_MAX;
        default: begin
          if (b.max_time > b.min_time)
            r.want_duration = TIME_W'(b.min_time +
                ({$urandom, $urandom} % (b.max_time - b.min_time + 1)));
          else
            r.want_duration = TIME_W'({$urandom, $urandom} & TIME_MAX);
        end
      endcase
      move_q.push_back(r);
    end
  endtask

  task automatic drain();
    wait (move_q.size() == 0 && plan_q.size() == 0);
    repeat (240) @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: defaults first
    add_move(0, 0, 48'd1000);
    add_move(32'sh7FFF_FFFF, 32'sh8000_0000, 48'd0);
    add_move(32'sh8000_0000, 32'sh7FFF_FFFF, TIME_MAX);
    add_move(0, 100, 48'd0);
    add_move(100, 0, TIME_MAX);
    add_move(0, 16000, 48'h5_0000);
    add_move(0, 16001, 48'h6_0000);
    add_move(-5, 5, 48'h2_8000);
    add_move(0, 1, 48'h1);
    add_move(-1000000, 1000000, 48'h1000_0000);
    add_move(0, 5555, 48'hFFFF_FFFF_FFFF);
    add_move(12, 9, 48'h8000_0000_0000);
    drain();

    // zero registers act as one; huge distance saturates min_time
    set_regs('0, '0, '0);
    add_move(32'sh8000_0000, 32'sh7FFF_FFFF, 48'h1234_5678_9ABC);
    add_move(0, 3, 48'h1_8000);
    add_move(0, 1000, 48'h100_0000);
    add_move(7, 7, 48'd5);
    drain();

    set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_move(0, 1, 48'h1);
    add_move(32'sh8000_0000, 32'sh7FFF_FFFF, 48'h1_0000);
    add_move(0, 65535, 48'h2_0000);
    add_move(-70000, 70000, TIME_MAX);
    drain();

    // random phases, with the long receiver hold in one of them
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: set_regs(ACCEL_RST, SPEED_TOP_RST, SPEED_FLOOR_RST);
        1: set_regs(16'd1, 16'hFFFF, 16'd1);
        2: set_regs(16'hFFFF, 16'd1, 16'hFFFF);
        default: set_regs(CFG_W'($urandom_range(1, 65535) >> $urandom_range(0, 15)),
                          CFG_W'($urandom_range(1, 65535) >> $urandom_range(0, 15)),
                          CFG_W'($urandom_range(1, 65535) >> $urandom_range(0, 15)));
      endcase
      steady_send = (ph == 3);
      steady_recv = (ph == 4);
      add_random_moves(250);
      if (ph == 2) begin
        steady_send = 1'b1;
        hold_req_cnt++;
      end
      drain();
    end

    if (failed)
      $display("trapezoid_move_time_speed_solver_unit regression: fail");
    else
      $display("trapezoid_move_time_speed_solver_unit regression: pass");
    $finish;
  end

  initial begin
    #20ms;
    $display("trapezoid_move_time_speed_solver_unit regression: fail");
    $finish;
  end

endmodule
